// ----- hw/rtl/lpcr2d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcr2d_pkg
// Shared types, constants and arithmetic for the reflection to direct-form
// converter: command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package lpcr2d_pkg;

	localparam int ORDER  = 14;
	localparam int IDX_W  = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int CNT_W  = $clog2(ORDER + 1);
	localparam int COEF_W = 16;
	localparam int PROD_W = 2 * COEF_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int SHIFT  = 15;

	localparam logic signed [COEF_W-1:0] COEF0      = 16'sh2000;
	localparam logic signed [ACC_W-1:0]  ROUND_BIAS = ACC_W'(1) <<< (SHIFT - 1);
	localparam logic signed [ACC_W-1:0]  TRUNC_BIAS = (ACC_W'(1) <<< SHIFT) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0]  SAT_MAX    = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0]  SAT_MIN    = -ACC_W'(32768);

	// write source codes
	localparam logic [1:0] WSRC_INIT  = 2'd0;
	localparam logic [1:0] WSRC_UPD_A = 2'd1;
	localparam logic [1:0] WSRC_UPD_B = 2'd2;

	// multiplier operand select
	localparam logic MSEL_B = 1'b0;
	localparam logic MSEL_A = 1'b1;

	// output word source
	localparam logic OSRC_CONST = 1'b0;
	localparam logic OSRC_MEM   = 1'b1;

	typedef struct packed {
		logic             k_ld;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [1:0]       wsrc;
		logic             re;
		logic [IDX_W-1:0] raddr_a;
		logic [IDX_W-1:0] raddr_b;
		logic             mul_en;
		logic             mul_sel;
		logic             out_ld;
		logic             out_src;
		logic             out_last;
	} cmd_t;

	typedef struct packed {
		logic out_valid;
	} status_t;

	// (prod + self*2^15 + 2^14) / 2^15, truncated toward zero, saturated
	function automatic logic signed [COEF_W-1:0] pair_update(
		input logic signed [PROD_W-1:0] prod,
		input logic signed [COEF_W-1:0] self_v
	);
		logic signed [ACC_W-1:0] num;
		logic signed [ACC_W-1:0] quo;
		num = ACC_W'(prod) + (ACC_W'(self_v) <<< SHIFT) + ROUND_BIAS;
		if (num[ACC_W-1]) begin
			num = num + TRUNC_BIAS;
		end
		quo = num >>> SHIFT;
		if (quo > SAT_MAX) begin
			pair_update = SAT_MAX[COEF_W-1:0];
		end else if (quo < SAT_MIN) begin
			pair_update = SAT_MIN[COEF_W-1:0];
		end else begin
			pair_update = quo[COEF_W-1:0];
		end
	endfunction

endpackage

// ----- hw/rtl/lpc_reflection_to_direct_form.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_reflection_to_direct_form
// Step-up recursion from Q15 reflection coefficients to Q13 direct-form
// predictor coefficients, one shared multiplier over the coefficient pairs.
// ----------------------------------------------------------------------------
// stage m (from 0) is one store write, then for each of its ceil(m/2) pairs
// a read, two multiplies and two writes on the single multiplier
// after the last stage 15 words leave, each loaded only after the previous
// one is taken, and no new word is taken until the last one is delivered
// arst_n clears the sequencer and the stage counter; the store needs no reset
// ----------------------------------------------------------------------------
module lpc_reflection_to_direct_form
	import lpcr2d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [15:0] refl_coef
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] pred_coef
	output logic        m_axis_tlast   // coef_last
);

	cmd_t                     cmd;
	status_t                  status;
	logic signed [COEF_W-1:0] out_coef;

	lpcr2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	lpcr2d_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.k_in      ($signed(s_axis_tdata)),
		.out_ready (m_axis_tready),
		.out_coef  (out_coef),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tvalid = status.out_valid;
	assign m_axis_tdata  = out_coef;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while an output word is pending");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not ready for a new set after the last word");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready && !m_axis_tvalid))
		else $error("stage work skipped after accepting a word");
`endif

endmodule

// ----- hw/rtl/lpcr2d_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcr2d_datapath
// Coefficient store, shared multiplier, pair update arithmetic and the
// output word register.
// ----------------------------------------------------------------------------
module lpcr2d_datapath
	import lpcr2d_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output status_t                  status,
	input  logic signed [COEF_W-1:0] k_in,
	input  logic                     out_ready,
	output logic signed [COEF_W-1:0] out_coef,
	output logic                     out_last
);

	logic signed [COEF_W-1:0] mem [ORDER];
	logic signed [COEF_W-1:0] rd_a_q;
	logic signed [COEF_W-1:0] rd_b_q;
	logic signed [COEF_W-1:0] k_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [COEF_W-1:0] mul_op;
	logic signed [COEF_W-1:0] wdata;
	logic signed [COEF_W-1:0] out_coef_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	assign mul_op = (cmd.mul_sel == MSEL_A) ? rd_a_q : rd_b_q;

	always_comb begin
		case (cmd.wsrc)
			WSRC_INIT:  wdata = k_in >>> 2;
			WSRC_UPD_A: wdata = pair_update(prod_q, rd_a_q);
			WSRC_UPD_B: wdata = pair_update(prod_q, rd_b_q);
			default:    wdata = k_in >>> 2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= wdata;
		end
		if (cmd.re) begin
			rd_a_q <= mem[cmd.raddr_a];
			rd_b_q <= mem[cmd.raddr_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.k_ld) begin
			k_q <= k_in;
		end
		if (cmd.mul_en) begin
			prod_q <= k_q * mul_op;
		end
		if (cmd.out_ld) begin
			out_coef_q <= (cmd.out_src == OSRC_MEM) ? rd_a_q : COEF0;
			out_last_q <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_valid = out_valid_q;
	assign out_coef         = out_coef_q;
	assign out_last         = out_last_q;

endmodule

// ----- hw/rtl/lpcr2d_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpcr2d_ctrl
// Sequencer for the step-up recursion: stage, pair and emission counters
// and the command word for the datapath.
// ----------------------------------------------------------------------------
module lpcr2d_ctrl
	import lpcr2d_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_PCHK     = 4'd1;
	localparam logic [3:0] ST_RD       = 4'd2;
	localparam logic [3:0] ST_MUL1     = 4'd3;
	localparam logic [3:0] ST_MUL2     = 4'd4;
	localparam logic [3:0] ST_WR2      = 4'd5;
	localparam logic [3:0] ST_SEND     = 4'd6;
	localparam logic [3:0] ST_OUT_WAIT = 4'd7;
	localparam logic [3:0] ST_OUT_LD   = 4'd8;

	logic [3:0]       state_q;
	logic [3:0]       state_d;
	logic [IDX_W-1:0] m_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] e_q;
	logic [CNT_W-1:0] n_pairs;
	logic [CNT_W-1:0] lo_idx;
	logic [CNT_W-1:0] hi_idx;
	logic             taken;
	logic             accept;

	assign n_pairs = (CNT_W'(m_q) + CNT_W'(1)) >> 1;
	assign lo_idx  = i_q - CNT_W'(1);
	assign hi_idx  = CNT_W'(m_q) - i_q;
	assign taken   = status.out_valid && out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign accept  = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.k_ld  = 1'b1;
					cmd.we    = 1'b1;
					cmd.waddr = m_q;
					cmd.wsrc  = WSRC_INIT;
					state_d   = ST_PCHK;
				end
			end
			ST_PCHK: begin
				if (i_q <= n_pairs) begin
					state_d = ST_RD;
				end else if (m_q == IDX_W'(ORDER - 1)) begin
					state_d = ST_SEND;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				cmd.re      = 1'b1;
				cmd.raddr_a = lo_idx[IDX_W-1:0];
				cmd.raddr_b = hi_idx[IDX_W-1:0];
				state_d     = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_B;
				state_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.we      = 1'b1;
				cmd.waddr   = lo_idx[IDX_W-1:0];
				cmd.wsrc    = WSRC_UPD_A;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MSEL_A;
				state_d     = ST_WR2;
			end
			ST_WR2: begin
				cmd.we    = 1'b1;
				cmd.waddr = hi_idx[IDX_W-1:0];
				cmd.wsrc  = WSRC_UPD_B;
				state_d   = ST_PCHK;
			end
			ST_SEND: begin
				cmd.out_ld  = 1'b1;
				cmd.out_src = OSRC_CONST;
				state_d     = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (taken) begin
					if (e_q == CNT_W'(ORDER)) begin
						state_d = ST_IDLE;
					end else begin
						cmd.re      = 1'b1;
						cmd.raddr_a = e_q[IDX_W-1:0];
						cmd.raddr_b = e_q[IDX_W-1:0];
						state_d     = ST_OUT_LD;
					end
				end
			end
			ST_OUT_LD: begin
				cmd.out_ld   = 1'b1;
				cmd.out_src  = OSRC_MEM;
				cmd.out_last = (e_q == CNT_W'(ORDER));
				state_d      = ST_OUT_WAIT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q     <= '0;
			i_q     <= '0;
			e_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q <= CNT_W'(1);
					end
				end
				ST_PCHK: begin
					if (i_q > n_pairs) begin
						if (m_q == IDX_W'(ORDER - 1)) begin
							m_q <= '0;
							e_q <= '0;
						end else begin
							m_q <= m_q + IDX_W'(1);
						end
					end
				end
				ST_WR2: begin
					i_q <= i_q + CNT_W'(1);
				end
				ST_OUT_WAIT: begin
					if (taken && (e_q != CNT_W'(ORDER))) begin
						e_q <= e_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
